// ===== rtl/adsr_pkg.sv =====
// Shared types and constants for the linear ADSR envelope.
// Used by adsr_ctrl, adsr_dp and linear_adsr_envelope; depends on nothing.
package adsr_pkg;

	localparam int TIME_W  = 24;
	localparam int LEVEL_W = 16;
	localparam int STEP_W  = 10;
	localparam int PHASE_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W  = TIME_W + LEVEL_W;

	// quotient of every ramp division fits in LEVEL_W bits
	localparam int DIV_STEPS = LEVEL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [LEVEL_W-1:0] UNITY     = 16'd16384;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'd32768;

	localparam logic [TIME_W-1:0]  ATTACK_RST  = 24'd4800;
	localparam logic [TIME_W-1:0]  DECAY_RST   = 24'd24000;
	localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 16'd8192;
	localparam logic [TIME_W-1:0]  RELEASE_RST = 24'd96000;
	localparam logic [STEP_W-1:0]  STEP_RST    = 10'd1;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK  = 3'd0,
		CFG_DECAY   = 3'd1,
		CFG_SUSTAIN = 3'd2,
		CFG_RELEASE = 3'd3,
		CFG_STEP    = 3'd4
	} cfg_idx_t;

	// how the final level is formed: an immediate value or from the divider result
	typedef enum logic [1:0] {
		POST_IMM  = 2'd0,
		POST_QUO  = 2'd1,
		POST_DOWN = 2'd2,
		POST_UP   = 2'd3
	} post_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_MUL  = 2'd1,
		ST_DIV  = 2'd2,
		ST_DONE = 2'd3
	} ctrl_state_t;

	typedef struct packed {
		logic                 load;
		logic                 mul;
		logic                 div_step;
		logic                 div_first;
		logic [DIV_CNT_W-1:0] div_bit;
		logic                 out_load;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/adsr_ctrl.sv =====
// Controller FSM of the ADSR envelope: sequences accept, multiply,
// divide and output load. Depends on adsr_pkg.
module adsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  adsr_pkg::status_t status,
	output adsr_pkg::cmd_t    cmd
);

	adsr_pkg::ctrl_state_t state_q, state_nx;
	logic [adsr_pkg::DIV_CNT_W-1:0] bit_q, bit_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adsr_pkg::ST_IDLE;
			bit_q   <= '0;
		end else begin
			state_q <= state_nx;
			bit_q   <= bit_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		bit_nx        = bit_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.div_bit   = bit_q;
		cmd.div_first = (bit_q == adsr_pkg::DIV_CNT_W'(adsr_pkg::DIV_STEPS - 1));
		case (state_q)
			adsr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = status.need_div ? adsr_pkg::ST_MUL : adsr_pkg::ST_DONE;
				end
			end
			adsr_pkg::ST_MUL: begin
				cmd.mul  = 1'b1;
				bit_nx   = adsr_pkg::DIV_CNT_W'(adsr_pkg::DIV_STEPS - 1);
				state_nx = adsr_pkg::ST_DIV;
			end
			adsr_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				bit_nx       = bit_q - 1'b1;
				if (bit_q == '0) begin
					state_nx = adsr_pkg::ST_DONE;
				end
			end
			adsr_pkg::ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = adsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = adsr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/adsr_dp.sv =====
// Datapath of the ADSR envelope: settings, phase and elapsed time,
// 24x16 multiplier, radix-2 restoring divider, output register. Depends on adsr_pkg.
module adsr_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [adsr_pkg::TIME_W-1:0]        cfg_wdata,
	input  logic                               in_gate,
	input  logic                               in_trigger,
	input  adsr_pkg::cmd_t                     cmd,
	output adsr_pkg::status_t                  status,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [adsr_pkg::LEVEL_W-1:0]       out_level,
	output logic [adsr_pkg::PHASE_W-1:0]       out_phase
);

	localparam int TW = adsr_pkg::TIME_W;
	localparam int LW = adsr_pkg::LEVEL_W;

	logic [TW-1:0]               attack_q, decay_q, release_q;
	logic [LW-1:0]               sustain_q;
	logic [adsr_pkg::STEP_W-1:0] step_q;

	adsr_pkg::phase_t phase_q, ph_in, ph_nx;
	logic [TW-1:0]    elapsed_q, el_in, el_nx;
	logic [TW:0]      sum;
	logic [LW-1:0]    s_eff, diff, imm_nx;
	logic             need_div;
	adsr_pkg::post_t  post_nx, post_q;
	logic [TW-1:0]    a_nx, den_nx, mul_a_q, den_q;
	logic [LW-1:0]    b_nx, mul_b_q, imm_q;

	logic [adsr_pkg::PROD_W-1:0] prod_c, prod_q;
	logic [TW-1:0]               rem_src, rem_q;
	logic [TW:0]                 rem_sh;
	logic                        q_bit;
	logic [LW-1:0]               quo_q, level_sel;

	logic                        out_valid_q;
	logic [LW-1:0]               out_level_q;
	logic [adsr_pkg::PHASE_W-1:0] out_phase_q;

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= adsr_pkg::ATTACK_RST;
			decay_q   <= adsr_pkg::DECAY_RST;
			sustain_q <= adsr_pkg::SUSTAIN_RST;
			release_q <= adsr_pkg::RELEASE_RST;
			step_q    <= adsr_pkg::STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				adsr_pkg::CFG_ATTACK:  attack_q  <= cfg_wdata;
				adsr_pkg::CFG_DECAY:   decay_q   <= cfg_wdata;
				adsr_pkg::CFG_SUSTAIN: sustain_q <= cfg_wdata[LW-1:0];
				adsr_pkg::CFG_RELEASE: release_q <= cfg_wdata;
				adsr_pkg::CFG_STEP:    step_q    <= cfg_wdata[adsr_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_eff = (sustain_q > adsr_pkg::LEVEL_MAX) ? adsr_pkg::LEVEL_MAX : sustain_q;
	assign diff  = (s_eff <= adsr_pkg::UNITY) ? (adsr_pkg::UNITY - s_eff)
	                                          : (s_eff - adsr_pkg::UNITY);

	// one tick of the envelope; ramps that need a quotient go to the divider
	always_comb begin
		ph_in    = in_trigger ? adsr_pkg::PH_ATTACK : phase_q;
		el_in    = in_trigger ? '0 : elapsed_q;
		sum      = {1'b0, el_in} + (TW + 1)'(step_q);
		ph_nx    = ph_in;
		el_nx    = el_in;
		need_div = 1'b0;
		post_nx  = adsr_pkg::POST_IMM;
		imm_nx   = '0;
		a_nx     = sum[TW-1:0];
		b_nx     = adsr_pkg::UNITY;
		den_nx   = attack_q;
		case (ph_in)
			adsr_pkg::PH_ATTACK: begin
				if (sum >= {1'b0, attack_q}) begin
					ph_nx  = adsr_pkg::PH_DECAY;
					el_nx  = '0;
					imm_nx = adsr_pkg::UNITY;
				end else begin
					el_nx    = sum[TW-1:0];
					need_div = 1'b1;
					post_nx  = adsr_pkg::POST_QUO;
				end
			end
			adsr_pkg::PH_DECAY: begin
				if (sum >= {1'b0, decay_q}) begin
					ph_nx  = adsr_pkg::PH_SUSTAIN;
					el_nx  = '0;
					imm_nx = s_eff;
				end else begin
					el_nx    = sum[TW-1:0];
					need_div = 1'b1;
					post_nx  = (s_eff <= adsr_pkg::UNITY) ? adsr_pkg::POST_DOWN
					                                      : adsr_pkg::POST_UP;
					b_nx     = diff;
					den_nx   = decay_q;
				end
			end
			adsr_pkg::PH_SUSTAIN: begin
				imm_nx = s_eff;
				if (!in_gate) begin
					ph_nx = adsr_pkg::PH_RELEASE;
					el_nx = '0;
				end
			end
			adsr_pkg::PH_RELEASE: begin
				if (sum >= {1'b0, release_q}) begin
					ph_nx = adsr_pkg::PH_IDLE;
					el_nx = '0;
				end else begin
					el_nx    = sum[TW-1:0];
					need_div = 1'b1;
					post_nx  = adsr_pkg::POST_QUO;
					a_nx     = release_q - sum[TW-1:0];
					b_nx     = s_eff;
					den_nx   = release_q;
				end
			end
			default: begin
				ph_nx = adsr_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= adsr_pkg::PH_IDLE;
			elapsed_q <= '0;
		end else if (cmd.load) begin
			phase_q   <= ph_nx;
			elapsed_q <= el_nx;
		end
	end

	// divider: numerator < den * 2^LW, so the top TW bits start below den
	assign prod_c  = mul_a_q * mul_b_q;
	assign rem_src = cmd.div_first ? prod_q[adsr_pkg::PROD_W-1:LW] : rem_q;
	assign rem_sh  = {rem_src, prod_q[cmd.div_bit]};
	assign q_bit   = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mul_a_q <= a_nx;
			mul_b_q <= b_nx;
			den_q   <= den_nx;
			post_q  <= post_nx;
			imm_q   <= imm_nx;
		end
		if (cmd.mul) begin
			prod_q <= prod_c;
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? TW'(rem_sh - {1'b0, den_q}) : rem_sh[TW-1:0];
			quo_q <= {quo_q[LW-2:0], q_bit};
		end
		// phase is captured with the level so a waiting result stays intact
		if (cmd.out_load) begin
			out_level_q <= level_sel;
			out_phase_q <= phase_q;
		end
	end

	always_comb begin
		case (post_q)
			adsr_pkg::POST_IMM:  level_sel = imm_q;
			adsr_pkg::POST_QUO:  level_sel = quo_q;
			adsr_pkg::POST_DOWN: level_sel = adsr_pkg::UNITY - quo_q;
			adsr_pkg::POST_UP:   level_sel = adsr_pkg::UNITY + quo_q;
			default:             level_sel = imm_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.need_div = need_div;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_level       = out_level_q;
	assign out_phase       = out_phase_q;

endmodule

// ===== rtl/linear_adsr_envelope.sv =====
// Linear ADSR envelope: one item per sample tick, one result item per tick.
// When the level needs no ramp quotient (stage end, sustain, idle), an accepted item goes
// straight to the output load; otherwise it passes the multiply, then the bit-serial divider
// for all 16 quotient bits, then the output load, which waits for room in the output register.
// The divider serves one item at a time; the next is taken in the cycle after the output load.
// arst_n clears phase to idle, elapsed to zero and loads the default settings.
module linear_adsr_envelope (
	input  logic        clk,
	input  logic        arst_n,
	// settings write port, index = register order
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_wdata,
	// tick input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] gate, [1] trigger, [7:2] zero
	// envelope output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [15:0] level, [18:16] phase_code, [23:19] zero
);

	adsr_pkg::cmd_t    cmd;
	adsr_pkg::status_t status;
	logic [adsr_pkg::LEVEL_W-1:0] level;
	logic [adsr_pkg::PHASE_W-1:0] phase_code;

	// controller: IDLE takes an item, MUL/DIV run the ramp quotient,
	// DONE waits for room in the output register
	adsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: phase/elapsed update happens on accept; the output register
	// frees the input side while a result waits
	adsr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_gate    (s_axis_tdata[0]),
		.in_trigger (s_axis_tdata[1]),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_level  (level),
		.out_phase  (phase_code)
	);

	assign m_axis_tdata = {5'b0, phase_code, level};

	// no second item while one is in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item accepted while previous tick still in flight");

	// idle phase always reports a zero level
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && phase_code == adsr_pkg::PH_IDLE) |-> (level == '0))
		else $error("nonzero level in idle phase");

	// attack ramp stays below unity; the attack stage end reports unity in the decay phase
	a_attack_below_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && phase_code == adsr_pkg::PH_ATTACK) |-> (level < adsr_pkg::UNITY))
		else $error("attack level reached unity");

	// level never exceeds 2.0
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (level <= adsr_pkg::LEVEL_MAX))
		else $error("level above 2.0");

endmodule
